// ===== hw/rtl/qldu_pkg.sv =====
// ----------------------------------------------------------------------------
// qldu_pkg - shared types and constants for the quaternion unpacker
// Holds the pipeline word layout used by the front stages and the root cells.
// ----------------------------------------------------------------------------
package qldu_pkg;

   localparam int COMP_W     = 16;            // restored component width
   localparam int KEPT_W     = 15;            // carried truncated field width
   localparam int RAD_W      = 32;            // radicand width seen by the cells
   localparam int REM_W      = 18;            // partial remainder width
   localparam int ROOT_STEPS = 16;            // one root bit per cell

   localparam logic [RAD_W-1:0] ONE_SQ = 32'h4000_0000;  // one squared in Q30

   // Words that ride alongside the root computation.
   typedef struct packed {
      logic [2:0][COMP_W-1:0] kept;
      logic [1:0]             pos;
      logic                   neg;
   } qldu_side_type;

   // Contents of one pipeline cell.
   typedef struct packed {
      logic                   valid;
      logic [RAD_W-1:0]       rad;
      logic [REM_W-1:0]       rem;
      logic [COMP_W-1:0]      root;
      qldu_side_type          side;
   } qldu_cell_type;

endpackage

// ===== hw/rtl/qldu_if.sv =====
// ----------------------------------------------------------------------------
// qldu_req_if / qldu_rsp_if - valid/ready channels of the quaternion unpacker
// One interface for compressed words in and one for restored words out.
// ----------------------------------------------------------------------------
interface qldu_req_if;
   logic        valid;
   logic        ready;
   logic [14:0] kept_first;
   logic [14:0] kept_second;
   logic [14:0] kept_third;
   logic [1:0]  dropped_position;
   logic        dropped_negative;

   modport source (output valid, kept_first, kept_second, kept_third,
                   dropped_position, dropped_negative, input ready);
   modport sink   (input valid, kept_first, kept_second, kept_third,
                   dropped_position, dropped_negative, output ready);
endinterface

interface qldu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] comp_w;
   logic signed [15:0] comp_x;
   logic signed [15:0] comp_y;
   logic signed [15:0] comp_z;

   modport source (output valid, comp_w, comp_x, comp_y, comp_z, input ready);
   modport sink   (input valid, comp_w, comp_x, comp_y, comp_z, output ready);
endinterface

// ===== hw/rtl/quaternion_largest_dropped_unpack.sv =====
// ----------------------------------------------------------------------------
// quaternion_largest_dropped_unpack - smallest-three quaternion decompressor
// Restores four Q15 components from three kept fields and a dropped index.
// ----------------------------------------------------------------------------
// The block takes one compressed word per clock cycle and returns one restored
// word per cycle, in the order of acceptance, when the output side does not
// stall. Two front stages restore the kept components, square them and form
// the radicand 2^30 minus the sum of squares (zero when the sum reaches one).
// A chain of sixteen identical root cells then settles one bit of the dropped
// component each, and a final output register places the four components in
// their original order. Every stage moves together: the whole pipeline
// advances whenever the output register is empty or its word is being taken,
// so throughput is one word per cycle and a stall on the output holds every
// stage in place. When all three kept components are zero the dropped
// component is one, which wraps to 0x8000 (minus one) whatever its sign bit
// says; q and -q describe the same rotation, so this is harmless.
// ----------------------------------------------------------------------------
module quaternion_largest_dropped_unpack #(
   parameter int TRUNC_SHIFT = 1
) (
   input  logic              clock,
   input  logic              reset,
   qldu_req_if.sink          req_if,
   qldu_rsp_if.source        rsp_if
);
   import qldu_pkg::*;

   logic                     advance;
   qldu_cell_type            chain [ROOT_STEPS+1];

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [3:0][COMP_W-1:0]   comp_ff, comp_in;
   logic [COMP_W-1:0]        dropped;
   qldu_cell_type            last;

   // The output register decouples the sides: the chain moves whenever that
   // register is free or is being emptied in this cycle.
   assign advance       = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = advance;

   qldu_prep #(
      .TRUNC_SHIFT (TRUNC_SHIFT)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_if.valid),
      .in_kept  ({req_if.kept_third, req_if.kept_second, req_if.kept_first}),
      .in_pos   (req_if.dropped_position),
      .in_neg   (req_if.dropped_negative),
      .out_cell (chain[0])
   );

   // One cell per root bit, most significant bit first.
   for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_cell
      qldu_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_cell  (chain[g]),
         .out_cell (chain[g+1])
      );
   end

   // The negated root is taken modulo 2^16, as is the root of one itself.
   always_comb begin
      last         = chain[ROOT_STEPS];
      dropped      = last.side.neg ? (COMP_W'(0) - last.root) : last.root;
      rsp_valid_in = last.valid;
      unique case (last.side.pos)
         2'd0: comp_in = {last.side.kept[2], last.side.kept[1],
                          last.side.kept[0], dropped};
         2'd1: comp_in = {last.side.kept[2], last.side.kept[1],
                          dropped, last.side.kept[0]};
         2'd2: comp_in = {last.side.kept[2], dropped,
                          last.side.kept[1], last.side.kept[0]};
         2'd3: comp_in = {dropped, last.side.kept[2],
                          last.side.kept[1], last.side.kept[0]};
         default: comp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
         comp_ff      <= comp_in;
      end
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.comp_w = signed'(comp_ff[0]);
   assign rsp_if.comp_x = signed'(comp_ff[1]);
   assign rsp_if.comp_y = signed'(comp_ff[2]);
   assign rsp_if.comp_z = signed'(comp_ff[3]);

endmodule

// ===== hw/rtl/qldu_prep.sv =====
// ----------------------------------------------------------------------------
// qldu_prep - front stages of the quaternion unpacker
// Restores the kept components, squares them, and forms the radicand.
// ----------------------------------------------------------------------------
module qldu_prep #(
   parameter int TRUNC_SHIFT = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               in_valid,
   input  logic [2:0][qldu_pkg::KEPT_W-1:0]   in_kept,
   input  logic [1:0]                         in_pos,
   input  logic                               in_neg,
   output qldu_pkg::qldu_cell_type            out_cell
);
   import qldu_pkg::*;

   localparam logic [COMP_W-1:0] KEEP_MASK =
      COMP_W'((32'd1 << (COMP_W - TRUNC_SHIFT)) - 32'd1) & 16'h7FFF;

   logic signed [COMP_W-1:0] kept_val [3];
   logic signed [RAD_W-1:0]  sq_val   [3];

   logic                     a_valid_ff, a_valid_in;
   qldu_side_type            a_side_ff,  a_side_in;
   logic [2:0][RAD_W-1:0]    a_sq_ff,    a_sq_in;

   qldu_cell_type            b_cell_ff,  b_cell_in;
   logic [RAD_W-1:0]         sum;

   // Stage A: shift the truncated bits back into place and square them.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         kept_val[i] = signed'(({1'b0, in_kept[i]} & KEEP_MASK) << TRUNC_SHIFT);
         sq_val[i]   = kept_val[i] * kept_val[i];
         a_sq_in[i]  = RAD_W'(sq_val[i]);
         a_side_in.kept[i] = kept_val[i];
      end
      a_side_in.pos = in_pos;
      a_side_in.neg = in_neg;
      a_valid_in    = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
         a_side_ff  <= a_side_in;
         a_sq_ff    <= a_sq_in;
      end
   end

   // Stage B: the squares sum below 2^32; a sum at or above one gives a zero root.
   always_comb begin
      sum             = a_sq_ff[0] + a_sq_ff[1] + a_sq_ff[2];
      b_cell_in.valid = a_valid_ff;
      b_cell_in.rad   = (sum < ONE_SQ) ? (ONE_SQ - sum) : '0;
      b_cell_in.rem   = '0;
      b_cell_in.root  = '0;
      b_cell_in.side  = a_side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_cell_ff.valid <= 1'b0;
      end else if (advance) begin
         b_cell_ff <= b_cell_in;
      end
   end

   assign out_cell = b_cell_ff;

endmodule

// ===== hw/rtl/qldu_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// qldu_sqrt_cell - one step of the digit-by-digit integer square root
// Takes two radicand bits, decides one root bit and passes the word on.
// ----------------------------------------------------------------------------
module qldu_sqrt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  qldu_pkg::qldu_cell_type in_cell,
   output qldu_pkg::qldu_cell_type out_cell
);
   import qldu_pkg::*;

   logic [REM_W+1:0] rem_sh;
   logic [REM_W+1:0] trial;
   logic             take;
   qldu_cell_type    cell_ff, cell_in;

   always_comb begin
      rem_sh = {in_cell.rem, in_cell.rad[RAD_W-1 -: 2]};
      trial  = (REM_W+2)'({in_cell.root, 2'b01});
      take   = (rem_sh >= trial);

      cell_in       = in_cell;
      cell_in.rad   = {in_cell.rad[RAD_W-3:0], 2'b00};
      // The remainder never exceeds twice the root, so it fits its register.
      cell_in.rem   = take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      cell_in.root  = {in_cell.root[COMP_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign out_cell = cell_ff;

endmodule

// ===== hw/rtl/qldu_checker.sv =====
// ----------------------------------------------------------------------------
// qldu_checker - port-level checks for the quaternion unpacker
// Watches the two channels and is bound to the top level.
// ----------------------------------------------------------------------------
module qldu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_comp_w,
   input logic [15:0] rsp_comp_z
);

   // A stalled result word holds its valid and its w and z components.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_comp_w)
                                  && $stable(rsp_comp_z))
      else $error("stalled result word changed");

   // Nothing comes out in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid straight after reset");

   // With the output register free, the block always takes a new word.
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output register empty");

   // A result word being taken frees the whole pipeline for one step.
   a_ready_on_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> req_ready)
      else $error("input stalled while result word drained");

   // Ready only drops while a result word waits.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without an output stall");

endmodule

bind quaternion_largest_dropped_unpack qldu_checker u_qldu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_comp_w (rsp_if.comp_w),
   .rsp_comp_z (rsp_if.comp_z)
);

// ===== sim/qldu_unpack_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qldu_unpack_checker - result checker for the quaternion unpacker
// Watches both channels, predicts the restored quaternion for every accepted
// compressed word and compares each returned word with the oldest prediction.
// ----------------------------------------------------------------------------
module qldu_unpack_checker #(
   parameter int TRUNC_SHIFT = 1
) (
   input  logic clock,
   input  logic reset,
   qldu_req_if  req_if,
   qldu_rsp_if  rsp_if,
   output int   error_count,
   output int   words_in_flight
);
   import qldu_pkg::*;

   // Only the low 16-TRUNC_SHIFT bits of a kept field carry the component.
   localparam longint FIELD_MASK = ((64'd1 << (COMP_W - TRUNC_SHIFT)) - 1) & 64'h7FFF;

   typedef struct packed {
      logic signed [COMP_W-1:0] w;
      logic signed [COMP_W-1:0] x;
      logic signed [COMP_W-1:0] y;
      logic signed [COMP_W-1:0] z;
   } quat_q15_type;

   quat_q15_type awaited_quats[$];
   int           faults = 0;

   function automatic quat_q15_type restore_quaternion(
      input logic [KEPT_W-1:0] first_raw,
      input logic [KEPT_W-1:0] second_raw,
      input logic [KEPT_W-1:0] third_raw,
      input logic [1:0]        dropped_slot,
      input logic              dropped_neg
   );
      logic [KEPT_W-1:0]        raw [3];
      logic signed [COMP_W-1:0] kept [3];
      logic [COMP_W-1:0]        slot [4];
      logic [COMP_W-1:0]        dropped;
      longint unsigned          energy;
      longint unsigned          radicand;
      longint unsigned          root;
      longint unsigned          trial;
      int                       next_kept;
      quat_q15_type             word;
      raw[0] = first_raw;
      raw[1] = second_raw;
      raw[2] = third_raw;
      energy = 0;
      for (int i = 0; i < 3; i++) begin
         kept[i] = COMP_W'((longint'(raw[i]) & FIELD_MASK) << TRUNC_SHIFT);
         energy += longint'(kept[i]) * longint'(kept[i]);
      end
      // Largest root whose square still fits under one minus the kept energy.
      root = 0;
      if (energy < ONE_SQ) begin
         radicand = ONE_SQ - energy;
         for (int b = COMP_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand) root = trial;
         end
      end
      // A root of exactly one wraps to 0x8000 in either sign.
      dropped = dropped_neg ? COMP_W'(64'd0 - root) : COMP_W'(root);
      next_kept = 0;
      for (int i = 0; i < 4; i++) begin
         if (i == dropped_slot) begin
            slot[i] = dropped;
         end else begin
            slot[i] = kept[next_kept];
            next_kept++;
         end
      end
      word.w = slot[0];
      word.x = slot[1];
      word.y = slot[2];
      word.z = slot[3];
      return word;
   endfunction

   function automatic void check_component(input string name,
                                           input logic signed [COMP_W-1:0] want,
                                           input logic signed [COMP_W-1:0] got);
      if (got !== want) begin
         $display("[%0t] %s mismatch: expected %0d (0x%04h), actual %0d (0x%04h)",
                  $time, name, want, want, got, got);
         faults++;
      end
   endfunction

   always @(posedge clock) begin : watch
      quat_q15_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            awaited_quats.push_back(restore_quaternion(req_if.kept_first,
                                                       req_if.kept_second,
                                                       req_if.kept_third,
                                                       req_if.dropped_position,
                                                       req_if.dropped_negative));
         if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_quats.size() == 0) begin
               $display("[%0t] unexpected word: actual w=%0d x=%0d y=%0d z=%0d",
                        $time, rsp_if.comp_w, rsp_if.comp_x, rsp_if.comp_y,
                        rsp_if.comp_z);
               faults++;
            end else begin
               want = awaited_quats.pop_front();
               check_component("comp_w", want.w, rsp_if.comp_w);
               check_component("comp_x", want.x, rsp_if.comp_x);
               check_component("comp_y", want.y, rsp_if.comp_y);
               check_component("comp_z", want.z, rsp_if.comp_z);
            end
         end
      end
      error_count     <= faults;
      words_in_flight <= awaited_quats.size();
   end

endmodule

// ===== sim/quaternion_largest_dropped_unpack_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_largest_dropped_unpack_tb - testbench for the quaternion unpacker
// Drives compressed words through the block in phases of differing idling and
// back-pressure, while a separate checker predicts and compares every word.
// ----------------------------------------------------------------------------
module quaternion_largest_dropped_unpack_tb;
   import qldu_pkg::*;

   localparam int TRUNC_SHIFT    = 1;
   // Nothing moving on either channel for this long means the block is hung.
   // The deliberate hold-off on the result side is far shorter than this.
   localparam int WATCHDOG_LIMIT = 2000;
   // Covers the time the block takes to answer after acceptance, with margin.
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_CYCLES    = 200;
   // Largest magnitude of a kept component in a genuine unit quaternion,
   // 1/sqrt(2) in Q15.
   localparam int SMALLEST_MAX   = 23170;

   logic clock = 1'b0;
   logic reset;
   logic hold_request = 1'b0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   quiet_cycles = 0;
   int   error_count;
   int   words_in_flight;

   qldu_req_if req_if();
   qldu_rsp_if rsp_if();

   quaternion_largest_dropped_unpack #(
      .TRUNC_SHIFT(TRUNC_SHIFT)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   qldu_unpack_checker #(
      .TRUNC_SHIFT(TRUNC_SHIFT)
   ) unpack_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_if),
      .rsp_if          (rsp_if),
      .error_count     (error_count),
      .words_in_flight (words_in_flight)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Any word moving on either side counts as progress. Should the block sit
   // still for too long the run is abandoned as a failure.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("[quaternion_largest_dropped_unpack] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side. Ready changes only on the falling edge. When a hold-off is
   // requested, ready stays low until the hold-off counted here has run out, so
   // that the pipeline fills and the input side is forced to stall.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Offers one compressed word, with random idle cycles beforehand according
   // to the current phase, and returns at the rising edge that accepts it.
   // Valid is only lowered when an idle cycle is actually inserted, so
   // back-to-back words never see valid dropped and raised in one step.
   task automatic offer_word(input logic [KEPT_W-1:0] first_raw,
                             input logic [KEPT_W-1:0] second_raw,
                             input logic [KEPT_W-1:0] third_raw,
                             input logic [1:0]        position,
                             input logic              negative);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid            <= 1'b1;
      req_if.kept_first       <= first_raw;
      req_if.kept_second      <= second_raw;
      req_if.kept_third       <= third_raw;
      req_if.dropped_position <= position;
      req_if.dropped_negative <= negative;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Truncates a signed Q15 value to the field the packer would have sent.
   function automatic logic [KEPT_W-1:0] encode_kept(input int value);
      logic [COMP_W-1:0] bits;
      bits = COMP_W'(value);
      return KEPT_W'(bits >> TRUNC_SHIFT);
   endfunction

   // Mostly words that a real packer would produce (each kept component no
   // larger than 1/sqrt(2)), where the sum of squares may still exceed one.
   // The rest is unconstrained noise and a scatter of awkward field values.
   task automatic offer_random_word();
      logic [KEPT_W-1:0] field [3];
      int                style;
      style = $urandom_range(99);
      for (int i = 0; i < 3; i++) begin
         if (style < 70) begin
            field[i] = encode_kept(int'($urandom_range(2 * SMALLEST_MAX)) - SMALLEST_MAX);
         end else if (style < 90) begin
            field[i] = KEPT_W'($urandom);
         end else begin
            case ($urandom_range(5))
               0:       field[i] = '0;
               1:       field[i] = KEPT_W'(1);
               2:       field[i] = 15'h3FFF;
               3:       field[i] = 15'h4000;
               4:       field[i] = 15'h4001;
               default: field[i] = '1;
            endcase
         end
      end
      offer_word(field[0], field[1], field[2], 2'($urandom), 1'($urandom));
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) offer_random_word();
   endtask

   initial begin
      reset                   = 1'b1;
      req_if.valid            = 1'b0;
      req_if.kept_first       = '0;
      req_if.kept_second      = '0;
      req_if.kept_third       = '0;
      req_if.dropped_position = '0;
      req_if.dropped_negative = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words. All kept components zero gives a root of exactly one,
      // which wraps to minus one regardless of the sign bit.
      offer_word('0, '0, '0, 2'd0, 1'b0);
      offer_word('0, '0, '0, 2'd3, 1'b1);
      // A kept component of minus one: the squares reach one and the dropped
      // component is zero.
      offer_word(15'h4000, '0, '0, 2'd1, 1'b0);
      offer_word(15'h4000, 15'h4000, 15'h4000, 2'd2, 1'b1);
      // Just below one, and all-ones fields that restore to tiny negatives.
      offer_word(15'h4001, '0, '0, 2'd0, 1'b1);
      offer_word(15'h3FFF, '0, KEPT_W'(1), 2'd2, 1'b0);
      offer_word('1, '1, '1, 2'd0, 1'b0);
      offer_word(15'h3FFF, 15'h3FFF, 15'h3FFF, 2'd3, 1'b1);
      offer_word(KEPT_W'(1), '0, '0, 2'd1, 1'b1);
      offer_word(15'h5555, 15'h2AAA, 15'h5555, 2'd1, 1'b0);
      offer_word(15'h2AAA, 15'h5555, 15'h2AAA, 2'd2, 1'b1);
      offer_word(encode_kept(SMALLEST_MAX), encode_kept(-SMALLEST_MAX),
                 encode_kept(SMALLEST_MAX), 2'd3, 1'b0);
      // A well-formed quaternion with the dropped component in every slot and
      // in both signs.
      for (int p = 0; p < 4; p++) begin
         offer_word(encode_kept(SMALLEST_MAX), encode_kept(8192), encode_kept(-8192),
                    2'(p), 1'b0);
         offer_word(encode_kept(SMALLEST_MAX), encode_kept(8192), encode_kept(-8192),
                    2'(p), 1'b1);
      end

      // Random words under each flow-control regime in turn.
      run_phase(0, 0, 200);
      run_phase(61, 0, 170);
      run_phase(0, 61, 170);
      run_phase(19, 19, 170);

      // Back-pressure: the result side holds off while words keep coming, so
      // the pipeline fills up and must refuse further input.
      hold_request = 1'b1;
      run_phase(0, 0, 100);

      @(negedge clock);
      req_if.valid <= 1'b0;
      recv_stall_pct = 0;
      while (words_in_flight != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("[quaternion_largest_dropped_unpack] OK");
      end else begin
         $display("[quaternion_largest_dropped_unpack] ERROR");
      end
      $finish;
   end

endmodule
